FILE: hw/rtl/rmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmsd_pkg;

	localparam int FIELD_W = 20;
	localparam int SUM_W   = 60;
	localparam int CNT_W   = 17;
	localparam int RMS_W   = 21;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int STEP_W  = $clog2(SUM_W);

	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_LVL_W = $clog2(JOBQ_DEPTH + 1);

	typedef struct packed {
		logic [FIELD_W-1:0] first_x;
		logic [FIELD_W-1:0] first_y;
		logic [FIELD_W-1:0] first_z;
		logic [FIELD_W-1:0] second_x;
		logic [FIELD_W-1:0] second_y;
		logic [FIELD_W-1:0] second_z;
		logic               last_pair;
	} pair_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms_value;
		logic [CNT_W-1:0] pairs_used;
		logic             overflow;
	} result_t;

	// one finished set, handed from accumulator to the divide/root unit
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_HOLD
	} back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rms_deviation_accumulator.sv
// Channel  | Handshake         | Payload             | Moves on
// pairs    | push / full       | pair   (pair_t)     | push && !full
// results  | pop / empty       | result (result_t)   | pop && !empty
//
// Pairs go in at one request per cycle while full is low, through a three-stage square-and-sum pipeline.
// A set's result comes from the shared bit-serial divider and square-root unit
// once its last pair has cleared the pipeline and the unit has taken its job.
// A four-entry job queue between accumulator and divider holds finished sets;
// full rises while four set ends are queued or in flight.
// Reset is asynchronous and leaves the block ready for a new set at once.
// The result register lets the unit start the next set while one result waits;
// a second finished result holds the unit until pop, and the job queue then backs up.
`timescale 1ns / 1ps
`default_nettype none

module rms_deviation_accumulator #(
	parameter int MAX_PAIRS  = 65536,
	parameter int COORD_BITS = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire rmsd_pkg::pair_t   pair,
	output logic                   empty,
	input  wire logic              pop,
	output rmsd_pkg::result_t      result
);

	logic                                job_push;
	rmsd_pkg::job_t                      wr_job;
	rmsd_pkg::job_t                      rd_job;
	logic                                job_pop;
	logic [rmsd_pkg::JOBQ_LVL_W-1:0]     jobq_level;

	rmsd_front #(
		.MAX_PAIRS  (MAX_PAIRS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pair       (pair),
		.jobq_level (jobq_level),
		.job_push   (job_push),
		.job        (wr_job)
	);

	rmsd_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (wr_job),
		.pop    (job_pop),
		.rd_job (rd_job),
		.level  (jobq_level)
	);

	rmsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (jobq_level != '0),
		.job       (rd_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/rmsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rmsd_front #(
	parameter int MAX_PAIRS  = 65536,
	parameter int COORD_BITS = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire rmsd_pkg::pair_t               pair,
	input  wire logic [rmsd_pkg::JOBQ_LVL_W-1:0] jobq_level,
	output logic                               job_push,
	output rmsd_pkg::job_t                     job
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int D2_W   = SQ_W + 2;
	localparam int CNT_W  = rmsd_pkg::CNT_W;
	localparam int SUM_W  = rmsd_pkg::SUM_W;
	localparam int PEND_W = rmsd_pkg::JOBQ_LVL_W + 1;

	logic                    accept;
	logic                    take;
	logic [CNT_W-1:0]        cnt_fin;
	logic                    drp_fin;
	logic [CNT_W-1:0]        count_q;
	logic                    drop_q;
	logic [PEND_W-1:0]       pending;

	logic signed [DIFF_W-1:0] ax, ay, az, bx, by, bz;
	logic signed [2*DIFF_W-1:0] px, py, pz;

	logic                     v_s1, last_s1, take_s1, drp_s1;
	logic [CNT_W-1:0]         cnt_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;

	logic                     v_s2, last_s2, take_s2, drp_s2;
	logic [CNT_W-1:0]         cnt_s2;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;

	logic                     v_s3, last_s3, take_s3, drp_s3;
	logic [CNT_W-1:0]         cnt_s3;
	logic [D2_W-1:0]          d2_s3;

	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         acc_next;

	// a set end in flight must find room in the job queue when it lands
	assign pending = PEND_W'(jobq_level) + PEND_W'(v_s1 & last_s1)
		+ PEND_W'(v_s2 & last_s2) + PEND_W'(v_s3 & last_s3);
	assign full    = pending >= PEND_W'(rmsd_pkg::JOBQ_DEPTH);
	assign accept  = push && !full;

	assign take    = count_q < CNT_W'(MAX_PAIRS);
	assign cnt_fin = take ? count_q + CNT_W'(1) : count_q;
	assign drp_fin = drop_q | !take;

	assign ax = {pair.first_x[COORD_BITS-1], pair.first_x[COORD_BITS-1:0]};
	assign ay = {pair.first_y[COORD_BITS-1], pair.first_y[COORD_BITS-1:0]};
	assign az = {pair.first_z[COORD_BITS-1], pair.first_z[COORD_BITS-1:0]};
	assign bx = {pair.second_x[COORD_BITS-1], pair.second_x[COORD_BITS-1:0]};
	assign by = {pair.second_y[COORD_BITS-1], pair.second_y[COORD_BITS-1:0]};
	assign bz = {pair.second_z[COORD_BITS-1], pair.second_z[COORD_BITS-1:0]};

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	assign acc_next = sum_q + (take_s3 ? SUM_W'(d2_s3) : '0);

	assign job_push    = v_s3 && last_s3;
	assign job.sum     = acc_next;
	assign job.count   = cnt_s3;
	assign job.dropped = drp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			count_q <= pair.last_pair ? '0 : cnt_fin;
			drop_q  <= pair.last_pair ? 1'b0 : drp_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				sum_q <= last_s3 ? '0 : acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= pair.last_pair;
		take_s1 <= take;
		cnt_s1  <= cnt_fin;
		drp_s1  <= drp_fin;
		dx_s1   <= ax - bx;
		dy_s1   <= ay - by;
		dz_s1   <= az - bz;

		last_s2 <= last_s1;
		take_s2 <= take_s1;
		cnt_s2  <= cnt_s1;
		drp_s2  <= drp_s1;
		sqx_s2  <= px[SQ_W-1:0];
		sqy_s2  <= py[SQ_W-1:0];
		sqz_s2  <= pz[SQ_W-1:0];

		last_s3 <= last_s2;
		take_s3 <= take_s2;
		cnt_s3  <= cnt_s2;
		drp_s3  <= drp_s2;
		d2_s3   <= D2_W'(sqx_s2) + D2_W'(sqy_s2) + D2_W'(sqz_s2);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count beyond capacity");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= PEND_W'(rmsd_pkg::JOBQ_DEPTH))
		else $error("more set ends in flight than job queue room");

endmodule

`default_nettype wire

FILE: hw/rtl/rmsd_jobq.sv
`timescale 1ns / 1ps
`default_nettype none

module rmsd_jobq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire rmsd_pkg::job_t                  wr_job,
	input  wire logic                            pop,
	output rmsd_pkg::job_t                       rd_job,
	output logic [rmsd_pkg::JOBQ_LVL_W-1:0]      level
);

	localparam int PTR_W = rmsd_pkg::JOBQ_PTR_W;
	localparam int LVL_W = rmsd_pkg::JOBQ_LVL_W;

	rmsd_pkg::job_t    mem_q [rmsd_pkg::JOBQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;

	assign rd_job = mem_q[rd_ptr_q];
	assign level  = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> level_q < LVL_W'(rmsd_pkg::JOBQ_DEPTH))
		else $error("job queue overrun");

endmodule

`default_nettype wire

FILE: hw/rtl/rmsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rmsd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_avail,
	input  wire rmsd_pkg::job_t              job,
	output logic                             job_pop,
	output logic                             empty,
	input  wire logic                        pop,
	output rmsd_pkg::result_t                result
);

	localparam int SUM_W  = rmsd_pkg::SUM_W;
	localparam int CNT_W  = rmsd_pkg::CNT_W;
	localparam int ROOT_W = rmsd_pkg::ROOT_W;
	localparam int STEP_W = rmsd_pkg::STEP_W;
	localparam int RMS_W  = rmsd_pkg::RMS_W;

	rmsd_pkg::back_state_t state_q, state_d;

	logic [SUM_W-1:0]    dvd_q;     // dividend, shifted out as the quotient comes in
	logic [CNT_W:0]      rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic                drp_q;
	logic [STEP_W-1:0]   step_q;
	logic [ROOT_W+1:0]   sq_rem_q;
	logic [ROOT_W-1:0]   root_q;
	rmsd_pkg::result_t   out_q;
	logic                out_v_q;

	logic [CNT_W:0]      rem_sh;
	logic                div_ge;
	logic [ROOT_W+1:0]   sq_try;
	logic [ROOT_W+1:0]   sq_sub;
	logic                sq_ge;
	logic                out_load;

	assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};

	assign sq_try = {sq_rem_q[ROOT_W-1:0], dvd_q[SUM_W-1 -: 2]};
	assign sq_sub = {root_q, 2'b01};
	assign sq_ge  = sq_try >= sq_sub;

	assign empty  = !out_v_q;
	assign result = out_q;

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			rmsd_pkg::ST_IDLE: begin
				if (job_avail) begin
					job_pop = 1'b1;
					state_d = rmsd_pkg::ST_DIV;
				end
			end
			rmsd_pkg::ST_DIV: begin
				if (step_q == '0) state_d = rmsd_pkg::ST_SQRT;
			end
			rmsd_pkg::ST_SQRT: begin
				if (step_q == '0) state_d = rmsd_pkg::ST_HOLD;
			end
			rmsd_pkg::ST_HOLD: begin
				if (!out_v_q || pop) begin
					out_load = 1'b1;
					state_d  = rmsd_pkg::ST_IDLE;
				end
			end
			default: state_d = rmsd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmsd_pkg::ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rmsd_pkg::ST_IDLE: begin
				dvd_q  <= job.sum;
				dvs_q  <= job.count;
				drp_q  <= job.dropped;
				rem_q  <= '0;
				step_q <= STEP_W'(SUM_W - 1);
			end
			rmsd_pkg::ST_DIV: begin
				rem_q <= div_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
				dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
				if (step_q == '0) begin
					step_q   <= STEP_W'(ROOT_W - 1);
					sq_rem_q <= '0;
					root_q   <= '0;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
			rmsd_pkg::ST_SQRT: begin
				// one root bit per step, two radicand bits in
				sq_rem_q <= sq_ge ? sq_try - sq_sub : sq_try;
				root_q   <= {root_q[ROOT_W-2:0], sq_ge};
				dvd_q    <= {dvd_q[SUM_W-3:0], 2'b00};
				step_q   <= step_q - STEP_W'(1);
			end
			rmsd_pkg::ST_HOLD: begin
				if (out_load) begin
					out_q.rms_value  <= (dvs_q == '0) ? '0 : root_q[RMS_W-1:0];
					out_q.pairs_used <= dvs_q;
					out_q.overflow   <= drp_q;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	a_hold_drains: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmsd_pkg::ST_HOLD && !out_v_q |=> out_v_q)
		else $error("finished root not moved to result register");

endmodule

`default_nettype wire
